/* rtl/core/i2d_pkg.sv */
// Shared types and constants for the 64-bit binary to decimal ASCII converter.
`default_nettype none
package i2d_pkg;
   localparam int unsigned ValueWidth = 64;
   localparam int unsigned MaxChars   = 20;
   localparam int unsigned CountWidth = 5;
   localparam int unsigned BcdWidth   = MaxChars * 4;
   localparam logic [7:0]  CharZero   = 8'd48;
   localparam logic [7:0]  CharMinus  = 8'd45;

   // One word in flight through the conversion pipeline.
   typedef struct packed {
      logic                  vld;
      logic                  neg;
      logic [ValueWidth-1:0] bin;
      logic [BcdWidth-1:0]   bcd;
   } conv_type;

   // Shift-add-3 step: add 3 to every BCD nibble at 5 or more, then shift in one bit.
   function automatic logic [BcdWidth-1:0] dabble_step(input logic [BcdWidth-1:0] bcd,
                                                       input logic bit_in);
      logic [BcdWidth-1:0] adj;
      adj = bcd;
      for (int n = 0; n < MaxChars; n++) begin
         if (bcd[n*4 +: 4] >= 4'd5) begin
            adj[n*4 +: 4] = bcd[n*4 +: 4] + 4'd3;
         end
      end
      return {adj[BcdWidth-2:0], bit_in};
   endfunction
endpackage
`default_nettype wire

/* rtl/core/i2d_dabble.sv */
// Pipelined double-dabble converter: binary magnitude in, BCD digits out.
`default_nettype none
module i2d_dabble
   import i2d_pkg::*;
#(
   parameter int unsigned BitsPerStage = 4
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     advance,
   input  wire conv_type stage_in,
   output conv_type      stage_out
);
   localparam int unsigned Stages = ValueWidth / BitsPerStage;

   conv_type pipe_ff [Stages];
   conv_type pipe_in [Stages];

   // BitsPerStage shift-add-3 steps on one word.
   function automatic conv_type run_stage(input conv_type word_in);
      conv_type cur;
      cur = word_in;
      for (int b = 0; b < BitsPerStage; b++) begin
         cur.bcd = dabble_step(cur.bcd, cur.bin[ValueWidth-1]);
         cur.bin = {cur.bin[ValueWidth-2:0], 1'b0};
      end
      return cur;
   endfunction

   always_comb begin
      pipe_in[0] = run_stage(stage_in);
      for (int s = 1; s < Stages; s++) begin
         pipe_in[s] = run_stage(pipe_ff[s-1]);
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < Stages; s++) begin
         if (reset) begin
            pipe_ff[s].vld <= 1'b0;
         end else if (advance) begin
            pipe_ff[s] <= pipe_in[s];
         end
      end
   end

   assign stage_out = pipe_ff[Stages-1];
endmodule
`default_nettype wire

/* rtl/core/int64_to_decimal_ascii.sv */
// Top level of the 64-bit binary to decimal ASCII converter.
// Each accepted word carries a mode bit and a 64-bit value; the block emits its decimal
// text one character per output word, most significant digit first, no leading zeros,
// '-' first for a negative value in signed mode (the most negative value prints exactly).
// The last character has tlast set and carries the character count in tuser.
// Pipeline: one negate stage plus 64/BitsPerStage double-dabble stages, then the
// character serializer. A number prints as 1 to 20 characters; the serializer holds one
// number at a time and the pipeline stalls behind it.
`default_nettype none
module int64_to_decimal_ascii
   import i2d_pkg::*;
#(
   parameter int unsigned BitsPerStage = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [71:0] req_tdata,   // [0] cmd, [64:1] value, zero fill
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [7:0]  rsp_tdata,   // [7:0] ascii_char
   output      logic        rsp_tlast,
   output      logic [4:0]  rsp_tuser    // [4:0] text_length
);
   localparam int unsigned IdxWidth = $clog2(MaxChars);

   conv_type neg_ff, neg_in, dab_out;
   logic advance;

   // Serializer state.
   logic                 busy_ff;
   logic                 neg_pending_ff;
   logic [BcdWidth-1:0]  digits_ff;
   logic [IdxWidth-1:0]  idx_ff;       // current digit index
   logic [CountWidth-1:0] count_ff;    // characters up to and including the current one
   logic                 load;
   logic [IdxWidth-1:0]  top_idx;

   // The pipeline moves unless its final word waits for a busy serializer.
   assign advance    = !(dab_out.vld && busy_ff);
   assign req_tready = advance;
   assign load       = dab_out.vld && !busy_ff;

   // Stage 0: sign decision and unsigned negation.
   always_comb begin
      neg_in.vld = req_tvalid;
      neg_in.neg = req_tdata[0] && req_tdata[64];
      neg_in.bin = neg_in.neg ? (ValueWidth'(0) - req_tdata[64:1]) : req_tdata[64:1];
      neg_in.bcd = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         neg_ff.vld <= 1'b0;
      end else if (advance) begin
         neg_ff <= neg_in;
      end
   end

   i2d_dabble #(.BitsPerStage(BitsPerStage)) u_dabble (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .stage_in (neg_ff),
      .stage_out(dab_out)
   );

   // Highest nonzero digit, zero value keeps index 0.
   always_comb begin
      top_idx = '0;
      for (int n = 0; n < MaxChars; n++) begin
         if (dab_out.bcd[n*4 +: 4] != 4'd0) begin
            top_idx = IdxWidth'(n);
         end
      end
   end

   logic fire;
   logic final_char;
   assign fire       = rsp_tvalid && rsp_tready;
   assign final_char = !neg_pending_ff && (idx_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (load) begin
         busy_ff <= 1'b1;
      end else if (fire && final_char) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         digits_ff      <= dab_out.bcd;
         neg_pending_ff <= dab_out.neg;
         idx_ff         <= top_idx;
         count_ff       <= CountWidth'(1);
      end else if (fire) begin
         count_ff <= count_ff + CountWidth'(1);
         if (neg_pending_ff) begin
            neg_pending_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff - IdxWidth'(1);
         end
      end
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = neg_pending_ff ? CharMinus
                                      : (CharZero + {4'd0, digits_ff[idx_ff*4 +: 4]});
   assign rsp_tlast  = final_char;
   assign rsp_tuser  = final_char ? count_ff : '0;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("output word changed while stalled");
   a_noload_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !(fire && final_char) |=> busy_ff)
      else $error("serializer dropped a number");
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser != '0 && rsp_tuser <= CountWidth'(MaxChars))
      else $error("bad character count");
endmodule
`default_nettype wire
